@@ src/svd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types and constants for the profile smoothing and valley detector.
// ----------------------------------------------------------------------------
package svd_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int ROW_W          = 10;
    localparam int COUNT_W        = 11;
    localparam int KLEN_W         = 7;
    localparam int LH_W           = 10;
    localparam int WIN_W          = 10;
    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 2;

    localparam int MAX_ROWS_DEF   = 1024;
    localparam int MAX_KERNEL_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_WINDOW  = 2'd2;

    localparam logic [KLEN_W-1:0] KERNEL_LEN_RST  = 7'd5;
    localparam logic [LH_W-1:0]   LINE_HEIGHT_RST = 10'd40;
    localparam logic [WIN_W-1:0]  SUM_WINDOW_RST  = 10'd20;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
        logic [ROW_W-1:0]       row;
    } cmd_t;

    typedef struct packed {
        logic                   result_kind;
        logic [SAMPLE_BITS-1:0] smoothed;
        logic                   is_valley;
        logic                   is_punctuation;
        logic [COUNT_W-1:0]     valley_count;
    } res_t;

endpackage

@@ src/svd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_div
// Iterative restoring divider, one quotient bit per cycle.
// The quotient must fit in Q_W bits (num >> Q_W below den).
// ----------------------------------------------------------------------------
module svd_div #(
    parameter int N_W = 17,
    parameter int D_W = 8,
    parameter int Q_W = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [Q_W-1:0] quo
);

    localparam int C_W = $clog2(Q_W + 1);

    logic [D_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0] low_reg, low_next;
    logic [C_W-1:0] cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;
    logic [D_W-1:0] den_reg, den_next;
    logic [D_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        trial     = {rem_reg, low_reg[Q_W-1]};
        if (go)
        begin
            rem_next = num[N_W-1:Q_W];
            low_next = num[Q_W-1:0];
            den_next = den;
            cnt_next = C_W'(Q_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = D_W'(trial - {1'b0, den_reg});
                low_next = {low_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[D_W-1:0];
                low_next = {low_reg[Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == C_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = low_reg;

endmodule

@@ src/svd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_core
// Profile store and pass sequencer: smoothing, valley scan, punctuation test.
// ----------------------------------------------------------------------------
module svd_core #(
    parameter int MAX_ROWS   = svd_pkg::MAX_ROWS_DEF,
    parameter int MAX_KERNEL = svd_pkg::MAX_KERNEL_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  svd_pkg::cmd_t                        cmd,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]      klen,
    input  logic [svd_pkg::LH_W-1:0]             lh,
    input  logic [svd_pkg::WIN_W-1:0]            sw,
    output logic                                 busy,
    output logic                                 strobe,
    output svd_pkg::res_t                        res
);

    localparam int SB     = svd_pkg::SAMPLE_BITS;
    localparam int ADDR_W = $clog2(MAX_ROWS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int KL_W   = $clog2(MAX_KERNEL + 1);
    localparam int ZW     = (KL_W > 3) ? KL_W : 3;
    localparam int SUM_W  = SB + KL_W;
    localparam int TOT_W  = SB + CNT_W;
    localparam int WS_W   = SB + svd_pkg::WIN_W;
    localparam int H_W    = svd_pkg::LH_W - 2;
    localparam int M_W    = 2 * H_W;
    localparam int RA_W   = $clog2(MAX_ROWS + MAX_KERNEL + 8) + 1;
    localparam int CMP_W  = (CNT_W > svd_pkg::ROW_W) ? CNT_W : svd_pkg::ROW_W;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_OUT, S_M, S_SUM_RD, S_SUM_AC, S_ROW_RD, S_ROW_RD2,
        S_DIV_GO, S_DIV_WAIT, S_VLD_RD, S_VLD_AC, S_EVAL, S_T_RD, S_T_AC,
        S_W_RD, S_W_AC, S_MARK, S_ADV, S_REPORT
    } state_t;

    logic [SB-1:0] prof_mem [MAX_ROWS];
    logic [1:0]    mark_mem [MAX_ROWS];
    logic [SB-1:0] prof_rdata;
    logic [1:0]    mark_rdata;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [ZW-1:0]    z_reg, z_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SB-1:0]    origj_reg, origj_next;
    logic [SB-1:0]    c_reg, c_next, a_reg, a_next, b_reg, b_next, d_reg, d_next;
    logic             seen_reg, seen_next;
    logic [CNT_W-1:0] lastv_reg, lastv_next;
    logic [CNT_W-1:0] vcnt_reg, vcnt_next;
    logic [M_W-1:0]   m_reg, m_next;
    logic [SB-1:0]    peak_reg, peak_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0] f_reg, f_next;
    logic [WS_W-1:0]  wsum_reg, wsum_next;
    logic [1:0]       mark_reg, mark_next;
    logic             ok_reg, ok_next;
    logic             rdok_reg, rdok_next;
    logic             strobe_reg, strobe_next;
    svd_pkg::res_t    res_reg, res_next;

    logic [RA_W-1:0]   raddr_full;
    logic [ADDR_W-1:0] raddr;
    logic              prof_we;
    logic [ADDR_W-1:0] prof_waddr;
    logic [SB-1:0]     prof_wdata;
    logic              mark_we;

    logic [SB-1:0]     v;
    logic [CNT_W-1:0]  nb;
    logic [H_W-1:0]    h;
    logic [H_W-1:0]    hp;
    logic [SB+1:0]     s3;
    logic              mono, spaced, hit;
    logic              div_go, div_done;
    logic [SB-1:0]     div_q;
    logic [SUM_W:0]    div_num;
    logic [KL_W:0]     div_den;

    svd_div #(
        .N_W (SUM_W + 1),
        .D_W (KL_W + 1),
        .Q_W (SB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    assign v       = ok_reg ? prof_rdata : '0;
    assign h       = lh[svd_pkg::LH_W-1:2];
    assign hp      = H_W'(({1'b0, h} + 1'b1) >> 1);
    assign s3      = {2'b00, a_reg} + {2'b00, b_reg} + {2'b00, d_reg};
    assign mono    = (a_reg <= b_reg) && (b_reg <= d_reg);
    assign spaced  = !seen_reg || (CMP_W'(j_reg - lastv_reg) >= CMP_W'(lh));
    assign hit     = ((c_reg <= SB'(2)) && (s3 >= 6) && mono && (a_reg >= SB'(1))
                      && (b_reg >= SB'(2)) && (d_reg >= SB'(3)) && spaced)
                  || ((j_reg == '0) && (c_reg != '0) && (s3 >= 6) && (a_reg >= SB'(1))
                      && (b_reg >= SB'(2)) && (d_reg >= SB'(3)))
                  || ((c_reg <= SB'(4)) && (s3 >= 12) && mono && (a_reg >= SB'(3))
                      && (b_reg >= SB'(4)) && (d_reg >= SB'(5)) && spaced);
    assign div_num = {sum_reg, 1'b0} + (SUM_W + 1)'(klen);
    assign div_den = {klen, 1'b0};
    assign raddr   = raddr_full[ADDR_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        done_next   = done_reg;
        j_next      = j_reg;
        z_next      = z_reg;
        sum_next    = sum_reg;
        origj_next  = origj_reg;
        c_next      = c_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        d_next      = d_reg;
        seen_next   = seen_reg;
        lastv_next  = lastv_reg;
        vcnt_next   = vcnt_reg;
        m_next      = m_reg;
        peak_next   = peak_reg;
        total_next  = total_reg;
        steps_next  = steps_reg;
        t_next      = t_reg;
        f_next      = f_reg;
        wsum_next   = wsum_reg;
        mark_next   = mark_reg;
        rdok_next   = rdok_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        raddr_full  = RA_W'(j_reg);
        prof_we     = 1'b0;
        prof_waddr  = j_reg[ADDR_W-1:0];
        prof_wdata  = div_q;
        mark_we     = 1'b0;
        div_go      = 1'b0;
        nb          = done_reg ? '0 : n_reg;

        case (state_reg)
            S_IDLE:
            begin
                raddr_full = RA_W'(cmd.row);
                if (start)
                begin
                    if (cmd.action == svd_pkg::ACT_LOAD)
                    begin
                        done_next = 1'b0;
                        n_next    = nb;
                        if (nb < CNT_W'(MAX_ROWS))
                        begin
                            prof_we    = 1'b1;
                            prof_waddr = nb[ADDR_W-1:0];
                            prof_wdata = cmd.sample;
                            n_next     = nb + 1'b1;
                        end
                        if (cmd.last)
                            state_next = S_M;
                    end
                    else
                    begin
                        rdok_next  = done_reg && (CMP_W'(cmd.row) < CMP_W'(n_reg));
                        state_next = S_RD_OUT;
                    end
                end
            end
            S_RD_OUT:
            begin
                strobe_next                 = 1'b1;
                res_next                    = '0;
                res_next.result_kind        = svd_pkg::KIND_ROW;
                if (rdok_reg)
                begin
                    res_next.smoothed       = prof_rdata;
                    res_next.is_valley      = mark_rdata[0];
                    res_next.is_punctuation = mark_rdata[1];
                end
                state_next = S_IDLE;
            end
            S_M:
            begin
                m_next     = M_W'(h) * M_W'(hp);
                sum_next   = '0;
                z_next     = '0;
                j_next     = '0;
                state_next = S_SUM_RD;
            end
            S_SUM_RD:
            begin
                raddr_full = RA_W'(z_reg);
                state_next = S_SUM_AC;
            end
            S_SUM_AC:
            begin
                sum_next = sum_reg + SUM_W'(v);
                z_next   = z_reg + 1'b1;
                if (z_next == ZW'(klen))
                    state_next = S_ROW_RD;
                else
                    state_next = S_SUM_RD;
            end
            S_ROW_RD:
            begin
                state_next = S_ROW_RD2;
            end
            S_ROW_RD2:
            begin
                origj_next = v;
                raddr_full = RA_W'(j_reg) + RA_W'(klen);
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                div_go     = 1'b1;
                sum_next   = sum_reg - SUM_W'(origj_reg) + SUM_W'(v);
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    prof_we = 1'b1;
                    j_next  = j_reg + 1'b1;
                    if (j_next == n_reg)
                    begin
                        j_next     = '0;
                        z_next     = '0;
                        vcnt_next  = '0;
                        seen_next  = 1'b0;
                        lastv_next = '0;
                        state_next = S_VLD_RD;
                    end
                    else
                        state_next = S_ROW_RD;
                end
            end
            S_VLD_RD:
            begin
                raddr_full = RA_W'(z_reg);
                state_next = S_VLD_AC;
            end
            S_VLD_AC:
            begin
                c_next = a_reg;
                a_next = b_reg;
                b_next = d_reg;
                d_next = v;
                z_next = z_reg + 1'b1;
                if (z_reg == ZW'(3))
                    state_next = S_EVAL;
                else
                    state_next = S_VLD_RD;
            end
            S_EVAL:
            begin
                if (hit)
                begin
                    vcnt_next  = vcnt_reg + 1'b1;
                    seen_next  = 1'b1;
                    lastv_next = j_reg;
                    peak_next  = c_reg;
                    total_next = TOT_W'(c_reg);
                    steps_next = '0;
                    t_next     = j_reg + 1'b1;
                    state_next = S_T_RD;
                end
                else
                begin
                    mark_next  = 2'b00;
                    state_next = S_MARK;
                end
            end
            S_T_RD:
            begin
                raddr_full = RA_W'(t_reg);
                if (t_reg >= n_reg)
                begin
                    mark_next  = 2'b01;
                    state_next = S_MARK;
                end
                else
                    state_next = S_T_AC;
            end
            S_T_AC:
            begin
                if (peak_reg > v)
                begin
                    if ((CMP_W'(steps_reg) > CMP_W'(h)) || (total_reg > TOT_W'(m_reg)))
                    begin
                        mark_next  = 2'b01;
                        state_next = S_MARK;
                    end
                    else
                    begin
                        wsum_next  = '0;
                        f_next     = t_reg;
                        state_next = S_W_RD;
                    end
                end
                else
                begin
                    if (peak_reg < v)
                    begin
                        peak_next  = v;
                        total_next = total_reg + TOT_W'(v);
                        steps_next = steps_reg + 1'b1;
                    end
                    t_next     = t_reg + 1'b1;
                    state_next = S_T_RD;
                end
            end
            S_W_RD:
            begin
                raddr_full = RA_W'(t_reg);
                if ((t_reg >= n_reg) || (CMP_W'(t_reg - f_reg) >= CMP_W'(sw)))
                begin
                    mark_next  = {(wsum_reg > {WS_W'(m_reg), 1'b0}), 1'b1};
                    state_next = S_MARK;
                end
                else
                    state_next = S_W_AC;
            end
            S_W_AC:
            begin
                wsum_next  = wsum_reg + WS_W'(v);
                t_next     = t_reg + 1'b1;
                state_next = S_W_RD;
            end
            S_MARK:
            begin
                mark_we    = 1'b1;
                raddr_full = RA_W'(j_reg) + RA_W'(4);
                j_next     = j_reg + 1'b1;
                if (j_next == n_reg)
                    state_next = S_REPORT;
                else
                    state_next = S_ADV;
            end
            S_ADV:
            begin
                c_next     = a_reg;
                a_next     = b_reg;
                b_next     = d_reg;
                d_next     = v;
                state_next = S_EVAL;
            end
            S_REPORT:
            begin
                strobe_next           = 1'b1;
                res_next              = '0;
                res_next.result_kind  = svd_pkg::KIND_REPORT;
                res_next.valley_count = svd_pkg::COUNT_W'(vcnt_reg);
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ok_next = (raddr_full < RA_W'(n_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            done_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            seen_reg   <= 1'b0;
            vcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            done_reg   <= done_next;
            strobe_reg <= strobe_next;
            seen_reg   <= seen_next;
            vcnt_reg   <= vcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        z_reg     <= z_next;
        sum_reg   <= sum_next;
        origj_reg <= origj_next;
        c_reg     <= c_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        d_reg     <= d_next;
        lastv_reg <= lastv_next;
        m_reg     <= m_next;
        peak_reg  <= peak_next;
        total_reg <= total_next;
        steps_reg <= steps_next;
        t_reg     <= t_next;
        f_reg     <= f_next;
        wsum_reg  <= wsum_next;
        mark_reg  <= mark_next;
        ok_reg    <= ok_next;
        rdok_reg  <= rdok_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (prof_we)
            prof_mem[prof_waddr] <= prof_wdata;
        prof_rdata <= prof_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[j_reg[ADDR_W-1:0]] <= mark_reg;
        mark_rdata <= mark_mem[raddr];
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign res    = res_reg;

endmodule

@@ src/profile_smooth_valley_detect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_smooth_valley_detect
// Row profile smoothing and text-line valley detection for one strip.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. A load appends one
// sample while fewer than MAX_ROWS rows are held and gives no result. A load
// with last also runs the pass and then gives one report transaction carrying
// the valley count. A read gives one row transaction through the S_RD_OUT
// state and the result register. Each result is shown on res with strobe high
// for one cycle; res keeps it until the next result. A pass smooths the profile
// (one divider iteration per quotient bit), scans for valleys, and for each
// valley walks the rows of the ascender test and the summed window through the
// single profile memory read port. Registers are written through cfg_we,
// cfg_index and cfg_data by the user while idle; the block does not enforce it.
// Reset clears the row count and returns to loading; memory contents are
// left as they are and read back as zero until a pass has covered them.
// ----------------------------------------------------------------------------
module profile_smooth_valley_detect #(
    parameter int MAX_ROWS   = svd_pkg::MAX_ROWS_DEF,
    parameter int MAX_KERNEL = svd_pkg::MAX_KERNEL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  svd_pkg::cmd_t                   cmd,
    output logic                            strobe,
    output svd_pkg::res_t                   res,
    input  logic                            cfg_we,
    input  logic [svd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svd_pkg::CFG_W-1:0]       cfg_data
);

    localparam int KL_W = $clog2(MAX_KERNEL + 1);
    localparam int CK_W = (KL_W > svd_pkg::KLEN_W) ? KL_W : svd_pkg::KLEN_W;

    logic [svd_pkg::KLEN_W-1:0] klen_reg;
    logic [svd_pkg::LH_W-1:0]   lh_reg;
    logic [svd_pkg::WIN_W-1:0]  sw_reg;
    logic [KL_W-1:0]            klen_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg <= svd_pkg::KERNEL_LEN_RST;
            lh_reg   <= svd_pkg::LINE_HEIGHT_RST;
            sw_reg   <= svd_pkg::SUM_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                svd_pkg::CFG_KERNEL_LEN:  klen_reg <= cfg_data[svd_pkg::KLEN_W-1:0];
                svd_pkg::CFG_LINE_HEIGHT: lh_reg   <= cfg_data[svd_pkg::LH_W-1:0];
                svd_pkg::CFG_SUM_WINDOW:  sw_reg   <= cfg_data[svd_pkg::WIN_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        if (klen_reg == '0)
            klen_eff = KL_W'(1);
        else if (CK_W'(klen_reg) > CK_W'(MAX_KERNEL))
            klen_eff = KL_W'(MAX_KERNEL);
        else
            klen_eff = KL_W'(klen_reg);
    end

    svd_core #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .klen   (klen_eff),
        .lh     (lh_reg),
        .sw     (sw_reg),
        .busy   (busy),
        .strobe (strobe),
        .res    (res)
    );

endmodule
